// File: rtl/tlics_pkg.sv
package tlics_pkg;

    // Fixed field and accumulator widths
    localparam int ANG_W     = 30;  // per-ring angular running sum
    localparam int TOT_W     = 35;  // radial running sum of ring totals
    localparam int MUL_LO_W  = 32;  // low slice of the scaled operand
    localparam int BIN_W     = 6;   // bin index output fields
    localparam int FRAC_W    = 16;  // jitter pass-through fields

    // Parameter defaults
    localparam int RING_BINS_DEF   = 40;
    localparam int ANGLE_BINS_DEF  = 40;
    localparam int WEIGHT_BITS_DEF = 24;
    localparam int RAND_BITS_DEF   = 16;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;    // latch the accepted input word
        logic load_acc;   // add weight to ring sum, write angular entry
        logic ring_end;   // fold ring sum into total, write radial entry
        logic advance;    // step the load position
        logic rd_top;     // read the last entry of the current table
        logic mul;        // capture scaling products
        logic tgt;        // capture search target, restart index
        logic search;     // one compare step of the first-match search
        logic phase_ang;  // 0: ring level, 1: angle level
        logic out_load;   // move the finished result to the output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic hit;        // current entry matches or is the last one
        logic ring_last;  // load position sits on the last angle bin
    } sts_t;

endpackage

// File: rtl/tlics_ram.sv
module tlics_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/tlics_ctrl.sv
module tlics_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            opcode,
    output logic            in_ready,
    input  logic            out_ready,
    output logic            out_valid,
    input  tlics_pkg::sts_t sts,
    output tlics_pkg::cmd_t cmd
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_LOAD     = 12'b0000_0000_0010,
        S_RING_END = 12'b0000_0000_0100,
        S_RD_TOP   = 12'b0000_0000_1000,
        S_MUL_R    = 12'b0000_0001_0000,
        S_TGT_R    = 12'b0000_0010_0000,
        S_SRCH_R   = 12'b0000_0100_0000,
        S_RD_AT    = 12'b0000_1000_0000,
        S_MUL_A    = 12'b0001_0000_0000,
        S_TGT_A    = 12'b0010_0000_0000,
        S_SRCH_A   = 12'b0100_0000_0000,
        S_DONE     = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = opcode ? S_RD_TOP : S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load_acc = 1'b1;
                if (sts.ring_last)
                begin
                    state_next = S_RING_END;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_RING_END:
            begin
                cmd.ring_end = 1'b1;
                cmd.advance  = 1'b1;
                state_next   = S_IDLE;
            end
            S_RD_TOP:
            begin
                cmd.rd_top = 1'b1;
                state_next = S_MUL_R;
            end
            S_MUL_R:
            begin
                cmd.mul    = 1'b1;
                state_next = S_TGT_R;
            end
            S_TGT_R:
            begin
                cmd.tgt    = 1'b1;
                state_next = S_SRCH_R;
            end
            S_SRCH_R:
            begin
                cmd.search = 1'b1;
                if (sts.hit)
                begin
                    state_next = S_RD_AT;
                end
            end
            S_RD_AT:
            begin
                cmd.phase_ang = 1'b1;
                cmd.rd_top    = 1'b1;
                state_next    = S_MUL_A;
            end
            S_MUL_A:
            begin
                cmd.phase_ang = 1'b1;
                cmd.mul       = 1'b1;
                state_next    = S_TGT_A;
            end
            S_TGT_A:
            begin
                cmd.phase_ang = 1'b1;
                cmd.tgt       = 1'b1;
                state_next    = S_SRCH_A;
            end
            S_SRCH_A:
            begin
                cmd.phase_ang = 1'b1;
                cmd.search    = 1'b1;
                if (sts.hit)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                cmd.phase_ang = 1'b1;
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // The result stage is only entered right after the angle search finds its bin
    a_done_from_search: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) && ($past(state_reg) != S_DONE)
        |-> $past(state_reg) == S_SRCH_A)
        else $error("result stage entered without angle search");

endmodule

// File: rtl/tlics_dp.sv
module tlics_dp #(
    parameter int RING_BINS   = tlics_pkg::RING_BINS_DEF,
    parameter int ANGLE_BINS  = tlics_pkg::ANGLE_BINS_DEF,
    parameter int WEIGHT_BITS = tlics_pkg::WEIGHT_BITS_DEF,
    parameter int RAND_BITS   = tlics_pkg::RAND_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tlics_pkg::cmd_t              cmd,
    output tlics_pkg::sts_t              sts,
    input  logic [WEIGHT_BITS-1:0]       cell_weight,
    input  logic [RAND_BITS-1:0]         rand_ring,
    input  logic [RAND_BITS-1:0]         rand_angle,
    input  logic [tlics_pkg::FRAC_W-1:0] jitter_ring,
    input  logic [tlics_pkg::FRAC_W-1:0] jitter_angle,
    output logic [tlics_pkg::BIN_W-1:0]  ring_bin,
    output logic [tlics_pkg::FRAC_W-1:0] ring_fraction,
    output logic [tlics_pkg::BIN_W-1:0]  angle_bin,
    output logic [tlics_pkg::FRAC_W-1:0] angle_fraction
);

    localparam int ANG_W    = tlics_pkg::ANG_W;
    localparam int TOT_W    = tlics_pkg::TOT_W;
    localparam int LO_W     = tlics_pkg::MUL_LO_W;
    localparam int HI_W     = TOT_W - LO_W;
    localparam int BIN_W    = tlics_pkg::BIN_W;
    localparam int FRAC_W   = tlics_pkg::FRAC_W;
    localparam int CELLS    = RING_BINS * ANGLE_BINS;
    localparam int RIDX_W   = $clog2(RING_BINS);
    localparam int AIDX_W   = $clog2(ANGLE_BINS);
    localparam int CADDR_W  = $clog2(CELLS);
    localparam int IDX_W    = (RIDX_W > AIDX_W) ? RIDX_W : AIDX_W;
    localparam int SUM_W    = ((WEIGHT_BITS > ANG_W) ? WEIGHT_BITS : ANG_W) + 1;
    localparam int PLO_W    = LO_W + RAND_BITS;
    localparam int PHI_W    = HI_W + RAND_BITS;

    localparam logic [RIDX_W-1:0]  RING_LAST  = RIDX_W'(RING_BINS - 1);
    localparam logic [AIDX_W-1:0]  ANG_LAST   = AIDX_W'(ANGLE_BINS - 1);
    localparam logic [CADDR_W-1:0] CELL_LAST  = CADDR_W'(CELLS - 1);
    localparam logic [CADDR_W-1:0] ANG_STEP   = CADDR_W'(ANGLE_BINS);
    localparam logic [CADDR_W-1:0] ANG_TOP    = CADDR_W'(ANGLE_BINS - 1);
    localparam logic [IDX_W-1:0]   RIDX_LAST  = IDX_W'(RING_BINS - 1);
    localparam logic [IDX_W-1:0]   AIDX_LAST  = IDX_W'(ANGLE_BINS - 1);
    localparam logic [ANG_W-1:0]   ANG_MAX    = {ANG_W{1'b1}};
    localparam logic [TOT_W-1:0]   TOT_MAX    = {TOT_W{1'b1}};

    // Input word
    logic [WEIGHT_BITS-1:0] weight_reg;
    logic [RAND_BITS-1:0]   rand_ring_reg;
    logic [RAND_BITS-1:0]   rand_angle_reg;
    logic [FRAC_W-1:0]      jit_ring_reg;
    logic [FRAC_W-1:0]      jit_angle_reg;

    // Load state
    logic [RIDX_W-1:0]      ld_ring_reg;
    logic [AIDX_W-1:0]      ld_ang_reg;
    logic [CADDR_W-1:0]     ld_addr_reg;
    logic [ANG_W-1:0]       ring_sum_reg;
    logic [TOT_W-1:0]       total_reg;

    // Draw state
    logic [PLO_W-1:0]       p_lo_reg;
    logic [PHI_W-1:0]       p_hi_reg;
    logic [TOT_W-1:0]       target_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [CADDR_W-1:0]     base_reg;
    logic [RIDX_W-1:0]      ring_sel_reg;

    // Output word
    logic [BIN_W-1:0]       ring_bin_reg;
    logic [BIN_W-1:0]       angle_bin_reg;
    logic [FRAC_W-1:0]      ring_frac_reg;
    logic [FRAC_W-1:0]      angle_frac_reg;

    logic [ANG_W-1:0]       ring_sum_base;
    logic [SUM_W-1:0]       ring_sum_wide;
    logic [ANG_W-1:0]       ring_sum_next;
    logic [TOT_W-1:0]       total_base;
    logic [TOT_W:0]         total_wide;
    logic [TOT_W-1:0]       total_next;

    logic [ANG_W-1:0]       a_rdata;
    logic [TOT_W-1:0]       r_rdata;
    logic [CADDR_W-1:0]     a_raddr;
    logic [RIDX_W-1:0]      r_raddr;

    logic [IDX_W-1:0]       idx_last;
    logic                   idx_at_last;
    logic [IDX_W-1:0]       idx_nxt;
    logic [TOT_W-1:0]       cand;
    logic                   hit;
    logic [RAND_BITS-1:0]   mul_r;
    logic [PLO_W-1:0]       p_lo_next;
    logic [PHI_W-1:0]       p_hi_next;
    logic [TOT_W-1:0]       target_next;

    // Load accumulation, saturating
    always_comb
    begin
        ring_sum_base = (ld_ang_reg == '0) ? '0 : ring_sum_reg;
        ring_sum_wide = SUM_W'(ring_sum_base) + SUM_W'(weight_reg);
        ring_sum_next = (ring_sum_wide > SUM_W'(ANG_MAX)) ? ANG_MAX
                                                           : ANG_W'(ring_sum_wide);
        total_base    = (ld_ring_reg == '0) ? '0 : total_reg;
        total_wide    = (TOT_W+1)'(total_base) + (TOT_W+1)'(ring_sum_reg);
        total_next    = total_wide[TOT_W] ? TOT_MAX : total_wide[TOT_W-1:0];
    end

    // Search step and scaling
    always_comb
    begin
        idx_last    = cmd.phase_ang ? AIDX_LAST : RIDX_LAST;
        idx_at_last = (idx_reg == idx_last);
        idx_nxt     = idx_at_last ? idx_reg : idx_reg + 1'b1;
        cand        = cmd.phase_ang ? TOT_W'(a_rdata) : r_rdata;
        hit         = (cand >= target_reg) || idx_at_last;
        mul_r       = cmd.phase_ang ? rand_angle_reg : rand_ring_reg;
        p_lo_next   = PLO_W'(cand[LO_W-1:0]) * PLO_W'(mul_r);
        p_hi_next   = PHI_W'(cand[TOT_W-1:LO_W]) * PHI_W'(mul_r);
        target_next = (TOT_W'(p_hi_reg) << (LO_W - RAND_BITS))
                    + TOT_W'(p_lo_reg >> RAND_BITS);
    end

    // Read addresses: table top, then prefetch one entry ahead of the compare
    always_comb
    begin
        if (cmd.rd_top)
        begin
            r_raddr = RING_LAST;
            a_raddr = base_reg + ANG_TOP;
        end
        else if (cmd.search)
        begin
            r_raddr = idx_nxt[RIDX_W-1:0];
            a_raddr = base_reg + CADDR_W'(idx_nxt);
        end
        else
        begin
            r_raddr = '0;
            a_raddr = base_reg;
        end
    end

    assign sts.hit       = hit;
    assign sts.ring_last = (ld_ang_reg == ANG_LAST);

    tlics_ram #(
        .WIDTH (ANG_W),
        .DEPTH (CELLS)
    ) u_ang_ram (
        .clk   (clk),
        .we    (cmd.load_acc),
        .waddr (ld_addr_reg),
        .wdata (ring_sum_next),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    tlics_ram #(
        .WIDTH (TOT_W),
        .DEPTH (RING_BINS)
    ) u_rad_ram (
        .clk   (clk),
        .we    (cmd.ring_end),
        .waddr (ld_ring_reg),
        .wdata (total_next),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_ring_reg  <= '0;
            ld_ang_reg   <= '0;
            ld_addr_reg  <= '0;
            ring_sum_reg <= '0;
            total_reg    <= '0;
        end
        else
        begin
            if (cmd.load_acc)
            begin
                ring_sum_reg <= ring_sum_next;
            end
            if (cmd.ring_end)
            begin
                total_reg <= total_next;
            end
            if (cmd.advance)
            begin
                ld_addr_reg <= (ld_addr_reg == CELL_LAST) ? '0 : ld_addr_reg + 1'b1;
                if (ld_ang_reg == ANG_LAST)
                begin
                    ld_ang_reg  <= '0;
                    ld_ring_reg <= (ld_ring_reg == RING_LAST) ? '0 : ld_ring_reg + 1'b1;
                end
                else
                begin
                    ld_ang_reg <= ld_ang_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            weight_reg     <= cell_weight;
            rand_ring_reg  <= rand_ring;
            rand_angle_reg <= rand_angle;
            jit_ring_reg   <= jitter_ring;
            jit_angle_reg  <= jitter_angle;
        end
        if (cmd.mul)
        begin
            p_lo_reg <= p_lo_next;
            p_hi_reg <= p_hi_next;
        end
        if (cmd.tgt)
        begin
            target_reg <= target_next;
            idx_reg    <= '0;
            if (!cmd.phase_ang)
            begin
                base_reg <= '0;
            end
        end
        if (cmd.search)
        begin
            if (hit)
            begin
                if (!cmd.phase_ang)
                begin
                    ring_sel_reg <= idx_reg[RIDX_W-1:0];
                end
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
                if (!cmd.phase_ang)
                begin
                    base_reg <= base_reg + ANG_STEP;
                end
            end
        end
        if (cmd.out_load)
        begin
            ring_bin_reg   <= BIN_W'(ring_sel_reg);
            angle_bin_reg  <= BIN_W'(idx_reg);
            ring_frac_reg  <= jit_ring_reg;
            angle_frac_reg <= jit_angle_reg;
        end
    end

    assign ring_bin       = ring_bin_reg;
    assign angle_bin      = angle_bin_reg;
    assign ring_fraction  = ring_frac_reg;
    assign angle_fraction = angle_frac_reg;

    a_load_pos_sync: assert property (@(posedge clk) disable iff (!rst_n)
        int'(ld_addr_reg) == int'(ld_ring_reg) * ANGLE_BINS + int'(ld_ang_reg))
        else $error("load cell address out of step with ring/angle counters");

    a_base_tracks_ring: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.search && !cmd.phase_ang
        |-> int'(base_reg) == int'(idx_reg) * ANGLE_BINS)
        else $error("ring base address out of step with ring index");

    a_ring_sum_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_acc && (ld_ang_reg != '0)
        |=> ring_sum_reg >= $past(ring_sum_reg))
        else $error("ring running sum decreased inside a ring");

endmodule

// File: rtl/two_level_inverse_cdf_sampler.sv
// Load: a load word passes through the load state, and on the last angle bin of a ring also the ring-end state.
// Draw: the result follows the table-top read, scaling, target and scan states for the ring
//   search and then for the angle search; each scan walks 1..RING_BINS or 1..ANGLE_BINS entries.
// Words are taken one at a time; a draw also stalls in its result state while an older result
//   waits, and the linear scans over one read port per RAM bound the draw rate.
// Reset: rst_n clears the load position and running sums; RAM contents stay undefined.
module two_level_inverse_cdf_sampler #(
    parameter int RING_BINS   = tlics_pkg::RING_BINS_DEF,
    parameter int ANGLE_BINS  = tlics_pkg::ANGLE_BINS_DEF,
    parameter int WEIGHT_BITS = tlics_pkg::WEIGHT_BITS_DEF,
    parameter int RAND_BITS   = tlics_pkg::RAND_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // input word
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         opcode,
    input  logic [WEIGHT_BITS-1:0]       cell_weight,
    input  logic [RAND_BITS-1:0]         rand_ring,
    input  logic [RAND_BITS-1:0]         rand_angle,
    input  logic [tlics_pkg::FRAC_W-1:0] jitter_ring,
    input  logic [tlics_pkg::FRAC_W-1:0] jitter_angle,
    // result word
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [tlics_pkg::BIN_W-1:0]  ring_bin,
    output logic [tlics_pkg::FRAC_W-1:0] ring_fraction,
    output logic [tlics_pkg::BIN_W-1:0]  angle_bin,
    output logic [tlics_pkg::FRAC_W-1:0] angle_fraction
);

    // The controller sequences each word:
    //   load: accumulate the weight into the ring sum and write the angular
    //         cumulative RAM; on the last bin of a ring, fold the ring sum into
    //         the saturating grand total and write the radial cumulative RAM.
    //   draw: read the grand total, scale it by rand_ring, scan the radial RAM
    //         for the first entry at or above the target; read that ring's
    //         total, scale by rand_angle, scan the ring's angular entries.
    // The scans walk entries one per cycle with a one-entry read prefetch and
    // stop on the first match, falling back to the last bin.
    // The result sits in an output register, so a new word is taken while the
    // previous result still waits for out_ready.

    tlics_pkg::cmd_t cmd;
    tlics_pkg::sts_t sts;

    tlics_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .opcode    (opcode),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    tlics_dp #(
        .RING_BINS   (RING_BINS),
        .ANGLE_BINS  (ANGLE_BINS),
        .WEIGHT_BITS (WEIGHT_BITS),
        .RAND_BITS   (RAND_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cell_weight    (cell_weight),
        .rand_ring      (rand_ring),
        .rand_angle     (rand_angle),
        .jitter_ring    (jitter_ring),
        .jitter_angle   (jitter_angle),
        .ring_bin       (ring_bin),
        .ring_fraction  (ring_fraction),
        .angle_bin      (angle_bin),
        .angle_fraction (angle_fraction)
    );

endmodule
